>>> hdl/ppc_pkg.sv
// ppc_pkg: widths, register indexes, reset values and shared types
// for the pi position controller; no dependencies
package ppc_pkg;

  localparam int POS_W      = 16;
  localparam int WIN_W      = 16;
  localparam int PGAIN_W    = 24;
  localparam int IGAIN_W    = 20;
  localparam int LIMIT_W    = 16;
  localparam int DRIVE_W    = 16;
  localparam int FRAC_SHIFT = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT  = 2'd3;

  // reset values
  localparam logic [WIN_W-1:0]   RST_ERROR_WINDOW = 16'd26;
  localparam logic [PGAIN_W-1:0] RST_P_GAIN       = 24'd840000;
  localparam logic [IGAIN_W-1:0] RST_I_GAIN       = 20'd2040;
  localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT  = 16'd20000;

  typedef struct packed {
    logic [WIN_W-1:0]   error_window;
    logic [PGAIN_W-1:0] p_gain;
    logic [IGAIN_W-1:0] i_gain;
    logic [LIMIT_W-1:0] drive_limit;
  } ppc_cfg_t;

  typedef struct packed {
    logic adv;
    logic vld;
  } ppc_stage_t;

  typedef struct packed {
    logic [POS_W-1:0] mag;
    logic             right;
  } ppc_err_t;

endpackage

>>> hdl/ppc_if.sv
// ppc_if: valid/ready channel interfaces for position words, drive words
// and configuration writes; depends on ppc_pkg
interface ppc_pos_if import ppc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] actual_position;
  logic [POS_W-1:0] reference_position;

  modport source (output valid, actual_position, reference_position, input ready);
  modport sink (input valid, actual_position, reference_position, output ready);
endinterface

interface ppc_drv_if import ppc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DRIVE_W-1:0] drive;
  logic               move_right;

  modport source (output valid, drive, move_right, input ready);
  modport sink (input valid, drive, move_right, output ready);
endinterface

interface ppc_cfg_if import ppc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/pi_position_controller.sv
// pi_position_controller: one result word per position word, passing from acceptance
// to a valid result through the input reg, sum/magnitude reg, product reg and
// output reg; throughput one word per cycle, the pipeline stalls as a whole
// only while a result waits at the output. reset clears the error sum, the
// stage valid bits and loads the register reset values
module pi_position_controller import ppc_pkg::*; #(
  parameter int SUM_WIDTH = 24
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  ppc_cfg_if.sink cfg_i,
  ppc_pos_if.sink pos_i,
  ppc_drv_if.source drv_o
);

  ppc_cfg_t             cfg;
  ppc_stage_t           stage_a;
  ppc_err_t             err_b;
  logic [SUM_WIDTH-1:0] sum_b;
  logic                 adv;
  logic                 vld_a_q, vld_b_q, vld_c_q, vld_out_q;
  logic [POS_W-1:0]     act_q, ref_q;

  // whole pipeline moves unless the output word is stuck
  assign adv         = !vld_out_q || drv_o.ready;
  assign pos_i.ready = adv;
  assign drv_o.valid = vld_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_out_q <= 1'b0;
    end else if (adv) begin
      vld_a_q   <= pos_i.valid;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_out_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      act_q <= pos_i.actual_position;
      ref_q <= pos_i.reference_position;
    end
  end

  assign stage_a.adv = adv;
  assign stage_a.vld = vld_a_q;

  ppc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  ppc_err_acc #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_err (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage_a),
    .act_i    (act_q),
    .ref_i    (ref_q),
    .window_i (cfg.error_window),
    .err_o    (err_b),
    .sum_o    (sum_b)
  );

  ppc_drive_calc #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_drive (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .cfg_i   (cfg),
    .err_i   (err_b),
    .sum_i   (sum_b),
    .drive_o (drv_o.drive),
    .right_o (drv_o.move_right)
  );

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && (err_b.mag > cfg.error_window)) |-> (sum_b == '0))
    else $error("error sum not cleared outside the window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && (err_b.mag <= cfg.error_window)) |-> (sum_b >= SUM_WIDTH'(err_b.mag)))
    else $error("error sum below the magnitude just added");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && err_b.right) |-> (err_b.mag != '0))
    else $error("right direction with zero error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_o.valid |-> (drv_o.drive <= cfg.drive_limit))
    else $error("drive above limit");
`endif

endmodule

>>> hdl/ppc_cfg_regs.sv
// ppc_cfg_regs: configuration register file, always ready for a write
// depends on ppc_pkg and ppc_cfg_if
module ppc_cfg_regs import ppc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppc_cfg_if.sink   cfg,
  output ppc_cfg_t  cfg_o
);

  ppc_cfg_t regs_q, regs_d;

  assign cfg.ready = 1'b1;
  assign cfg_o     = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ERROR_WINDOW: regs_d.error_window = cfg.data[WIN_W-1:0];
        CFG_P_GAIN:       regs_d.p_gain       = cfg.data[PGAIN_W-1:0];
        CFG_I_GAIN:       regs_d.i_gain       = cfg.data[IGAIN_W-1:0];
        CFG_DRIVE_LIMIT:  regs_d.drive_limit  = cfg.data[LIMIT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.error_window <= RST_ERROR_WINDOW;
      regs_q.p_gain       <= RST_P_GAIN;
      regs_q.i_gain       <= RST_I_GAIN;
      regs_q.drive_limit  <= RST_DRIVE_LIMIT;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

>>> hdl/ppc_err_acc.sv
// ppc_err_acc: error magnitude, direction and saturating error sum
// depends on ppc_pkg
module ppc_err_acc import ppc_pkg::*; #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppc_stage_t           stage_i,
  input  logic [POS_W-1:0]     act_i,
  input  logic [POS_W-1:0]     ref_i,
  input  logic [WIN_W-1:0]     window_i,
  output ppc_err_t             err_o,
  output logic [SUM_WIDTH-1:0] sum_o
);

  logic                 ref_gt;
  ppc_err_t             err_d, err_q;
  logic [SUM_WIDTH:0]   sum_ext;
  logic [SUM_WIDTH-1:0] sum_d, sum_q;

  assign ref_gt = ref_i > act_i;

  always_comb begin
    err_d.right = ref_gt;
    err_d.mag   = ref_gt ? (ref_i - act_i) : (act_i - ref_i);
    sum_ext     = {1'b0, sum_q} + (SUM_WIDTH + 1)'(err_d.mag);
    if (err_d.mag > window_i) begin
      sum_d = '0;
    end else if (sum_ext[SUM_WIDTH]) begin
      sum_d = '1;
    end else begin
      sum_d = sum_ext[SUM_WIDTH-1:0];
    end
  end

  // the sum moves only when a real word enters this stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (stage_i.adv && stage_i.vld) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_i.adv) begin
      err_q <= err_d;
    end
  end

  assign err_o = err_q;
  assign sum_o = sum_q;

endmodule

>>> hdl/ppc_drive_calc.sv
// ppc_drive_calc: registered gain products, then sum, shift and clamp
// depends on ppc_pkg
module ppc_drive_calc import ppc_pkg::*; #(
  parameter int SUM_WIDTH = 24
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  ppc_cfg_t             cfg_i,
  input  ppc_err_t             err_i,
  input  logic [SUM_WIDTH-1:0] sum_i,
  output logic [DRIVE_W-1:0]   drive_o,
  output logic                 right_o
);

  localparam int LO_W  = SUM_WIDTH / 2;
  localparam int HI_W  = SUM_WIDTH - LO_W;
  localparam int P_W   = PGAIN_W + POS_W;
  localparam int ILO_W = IGAIN_W + LO_W;
  localparam int IHI_W = IGAIN_W + HI_W;
  localparam int I_W   = IGAIN_W + SUM_WIDTH;
  localparam int ACC_W = ((P_W > I_W) ? P_W : I_W) + 1;
  localparam int U_W   = ACC_W - FRAC_SHIFT;

  logic [P_W-1:0]     p_prod_q;
  logic [ILO_W-1:0]   ilo_prod_q;
  logic [IHI_W-1:0]   ihi_prod_q;
  logic               right_c_q;
  logic [ACC_W-1:0]   acc;
  logic [U_W-1:0]     u;
  logic [DRIVE_W-1:0] drive_d, drive_q;
  logic               right_q;

  // i_gain * sum is split in two halves to keep each multiplier narrow
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_prod_q   <= P_W'(cfg_i.p_gain) * P_W'(err_i.mag);
      ilo_prod_q <= ILO_W'(cfg_i.i_gain) * ILO_W'(sum_i[LO_W-1:0]);
      ihi_prod_q <= IHI_W'(cfg_i.i_gain) * IHI_W'(sum_i[SUM_WIDTH-1:LO_W]);
      right_c_q  <= err_i.right;
    end
  end

  always_comb begin
    acc = ACC_W'(p_prod_q) + ACC_W'(ilo_prod_q) + (ACC_W'(ihi_prod_q) << LO_W);
    u   = acc[ACC_W-1:FRAC_SHIFT];
    if (u > U_W'(cfg_i.drive_limit)) begin
      drive_d = cfg_i.drive_limit;
    end else begin
      drive_d = u[DRIVE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      drive_q <= drive_d;
      right_q <= right_c_q;
    end
  end

  assign drive_o = drive_q;
  assign right_o = right_q;

endmodule

>>> bench/testbench.sv
// testbench for pi_position_controller: directed table, then randomized position words
// under several register settings, checked against a cycle-free predictor of the PI law
// depends on ppc_pkg, ppc_if and the controller rtl
`timescale 1ns / 1ps

module testbench;
  import ppc_pkg::*;

  localparam int          SUM_W        = 24;
  localparam logic [63:0] SUM_CEILING  = (64'd1 << SUM_W) - 64'd1;
  localparam int          LIMIT_CYCLES = 250000;
  localparam int          PROBE_N      = 22;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic               move_right;
  } drive_word_t;

  typedef struct packed {
    logic [POS_W-1:0]   act;
    logic [POS_W-1:0]   target;
    logic               typed;
    logic [DRIVE_W-1:0] drive;
    logic               right;
  } probe_t;

  // expected words are typed in only for the reset state and full-scale errors
  probe_t probes [PROBE_N] = '{
    '{16'h0000, 16'h0000, 1'b1, 16'd0,     1'b0},
    '{16'hFFFF, 16'hFFFF, 1'b1, 16'd0,     1'b0},
    '{16'h0000, 16'hFFFF, 1'b1, 16'd20000, 1'b1},
    '{16'hFFFF, 16'h0000, 1'b1, 16'd20000, 1'b0},
    '{16'h8000, 16'h8001, 1'b0, 16'd0,     1'b0},
    '{16'h1234, 16'h124E, 1'b0, 16'd0,     1'b0},
    '{16'h124E, 16'h1234, 1'b0, 16'd0,     1'b0},
    '{16'h03E8, 16'h0403, 1'b0, 16'd0,     1'b0},
    '{16'h00FF, 16'hFF00, 1'b0, 16'd0,     1'b0},
    '{16'hFF00, 16'h00FF, 1'b0, 16'd0,     1'b0},
    '{16'hAAAA, 16'h5555, 1'b0, 16'd0,     1'b0},
    '{16'h5555, 16'hAAAA, 1'b0, 16'd0,     1'b0},
    '{16'h01F4, 16'h01FE, 1'b0, 16'd0,     1'b0},
    '{16'h01FE, 16'h01F4, 1'b0, 16'd0,     1'b0},
    '{16'h01F4, 16'h01F4, 1'b0, 16'd0,     1'b0},
    '{16'h0001, 16'h0000, 1'b0, 16'd0,     1'b0},
    '{16'h0000, 16'h0001, 1'b0, 16'd0,     1'b0},
    '{16'hFFFE, 16'hFFFF, 1'b0, 16'd0,     1'b0},
    '{16'hFFFF, 16'hFFFE, 1'b0, 16'd0,     1'b0},
    '{16'h0100, 16'h0101, 1'b0, 16'd0,     1'b0},
    '{16'h0100, 16'h0100, 1'b0, 16'd0,     1'b0},
    '{16'h7FFF, 16'h8000, 1'b0, 16'd0,     1'b0}
  };

  logic clk;
  logic rst_n;

  ppc_cfg_if cfg_bus ();
  ppc_pos_if pos_bus ();
  ppc_drv_if drv_bus ();

  pi_position_controller #(
    .SUM_WIDTH(SUM_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .pos_i (pos_bus),
    .drv_o (drv_bus)
  );

  // predictor state
  logic [WIN_W-1:0]   model_window;
  logic [PGAIN_W-1:0] model_p_gain;
  logic [IGAIN_W-1:0] model_i_gain;
  logic [LIMIT_W-1:0] model_limit;
  logic [SUM_W-1:0]   model_sum;

  drive_word_t pending_drives [$];

  // typed expectation travelling with the word on the position channel
  logic               held_typed;
  logic [DRIVE_W-1:0] held_drive;
  logic               held_right;

  bit          send_calm;
  bit          recv_calm;
  int unsigned mismatches;
  int unsigned words_sent;
  int unsigned words_checked;
  int unsigned settings_used;
  int unsigned sat_ticks;
  int unsigned clamp_ticks;
  int unsigned cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d drive words outstanding", cycles,
               pending_drives.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // one control tick: direction, magnitude, integral update, PI sum and clamp
  function automatic drive_word_t control_tick(input logic [POS_W-1:0] act,
                                               input logic [POS_W-1:0] target);
    drive_word_t       res;
    logic [POS_W-1:0]  mag;
    logic [63:0]       grown;
    logic [63:0]       acc;
    logic [63:0]       scaled;
    if (target > act) begin
      res.move_right = 1'b1;
      mag = target - act;
    end else begin
      res.move_right = 1'b0;
      mag = act - target;
    end
    if (mag > model_window) begin
      model_sum = '0;
    end else begin
      grown = 64'(model_sum) + 64'(mag);
      if (grown > SUM_CEILING) begin
        grown = SUM_CEILING;
      end
      if (grown == SUM_CEILING) begin
        sat_ticks++;
      end
      model_sum = grown[SUM_W-1:0];
    end
    acc = 64'(model_p_gain) * 64'(mag) + 64'(model_i_gain) * 64'(model_sum);
    scaled = acc >> FRAC_SHIFT;
    if (scaled > 64'(model_limit)) begin
      res.drive = model_limit;
      clamp_ticks++;
    end else begin
      res.drive = scaled[DRIVE_W-1:0];
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch on %s at drive word %0d: expected %0d, got %0d", what,
               words_checked, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    drive_word_t want;
    drive_word_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_ERROR_WINDOW: model_window = cfg_bus.data[WIN_W-1:0];
          CFG_P_GAIN:       model_p_gain = cfg_bus.data[PGAIN_W-1:0];
          CFG_I_GAIN:       model_i_gain = cfg_bus.data[IGAIN_W-1:0];
          CFG_DRIVE_LIMIT:  model_limit  = cfg_bus.data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (pos_bus.valid && pos_bus.ready) begin
        want = control_tick(pos_bus.actual_position, pos_bus.reference_position);
        if (held_typed) begin
          want.drive      = held_drive;
          want.move_right = held_right;
        end
        pending_drives.push_back(want);
      end
      if (drv_bus.valid && drv_bus.ready) begin
        got.drive      = drv_bus.drive;
        got.move_right = drv_bus.move_right;
        if (pending_drives.size() == 0) begin
          flag_mismatch("unexpected drive word", 0, 32'(got.drive));
        end else begin
          want = pending_drives.pop_front();
          if (got.drive !== want.drive) begin
            flag_mismatch("drive", 32'(want.drive), 32'(got.drive));
          end
          if (got.move_right !== want.move_right) begin
            flag_mismatch("move_right", 32'(want.move_right), 32'(got.move_right));
          end
        end
        words_checked++;
      end
    end
  end

  // drive word receiver: random stall before every word, with calm stretches
  initial begin : drive_sink
    int unsigned stall;
    int unsigned taken;
    drv_bus.ready = 1'b0;
    taken = 0;
    recv_calm = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken % 32 == 0) begin
        recv_calm = ($urandom_range(0, 3) == 0);
      end
      stall = recv_calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        drv_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      drv_bus.ready <= 1'b1;
      do @(posedge clk); while (!(drv_bus.valid && drv_bus.ready));
      taken++;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_pos(input logic [POS_W-1:0] act, input logic [POS_W-1:0] target,
                          input logic typed, input logic [DRIVE_W-1:0] t_drive,
                          input logic t_right);
    int unsigned gap;
    gap = send_calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      pos_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pos_bus.valid              <= 1'b1;
    pos_bus.actual_position    <= act;
    pos_bus.reference_position <= target;
    held_typed                 <= typed;
    held_drive                 <= t_drive;
    held_right                 <= t_right;
    do @(posedge clk); while (!(pos_bus.valid && pos_bus.ready));
    @(negedge clk);
    words_sent++;
  endtask

  // stop sending and wait until every expected drive word is back
  task automatic settle();
    pos_bus.valid <= 1'b0;
    do @(negedge clk); while (pending_drives.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk);
  endtask

  task automatic apply_settings(input int unsigned window, input int unsigned p_gain,
                                input int unsigned i_gain, input int unsigned limit);
    write_reg(CFG_ERROR_WINDOW, CFG_DATA_W'(window));
    write_reg(CFG_P_GAIN, CFG_DATA_W'(p_gain));
    write_reg(CFG_I_GAIN, CFG_DATA_W'(i_gain));
    write_reg(CFG_DRIVE_LIMIT, CFG_DATA_W'(limit));
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  // mix of errors close to the setpoint (keeps the integral alive), full-scale
  // swings and fully random positions
  task automatic run_random(input int unsigned count, input int unsigned near_pct,
                            input int unsigned ext_pct, input int unsigned span);
    int unsigned      k;
    int unsigned      pick;
    int unsigned      offs;
    int unsigned      base;
    logic [POS_W-1:0] act;
    logic [POS_W-1:0] target;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        send_calm = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < ext_pct) begin
        act    = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        target = ($urandom_range(0, 7) == 0) ? act : ~act;
      end else if (pick < ext_pct + near_pct) begin
        base = $urandom_range(0, 65535);
        offs = $urandom_range(0, span);
        act  = POS_W'(base);
        if ($urandom_range(0, 1) != 0) begin
          target = (base + offs > 65535) ? 16'hFFFF : POS_W'(base + offs);
        end else begin
          target = (base < offs) ? 16'h0000 : POS_W'(base - offs);
        end
      end else begin
        act    = POS_W'($urandom_range(0, 65535));
        target = POS_W'($urandom_range(0, 65535));
      end
      send_pos(act, target, 1'b0, '0, 1'b0);
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    int unsigned window;
    rst_n                      = 1'b0;
    pos_bus.valid              = 1'b0;
    pos_bus.actual_position    = '0;
    pos_bus.reference_position = '0;
    cfg_bus.valid              = 1'b0;
    cfg_bus.index              = CFG_ERROR_WINDOW;
    cfg_bus.data               = '0;
    held_typed                 = 1'b0;
    held_drive                 = '0;
    held_right                 = 1'b0;
    send_calm                  = 1'b0;
    model_window               = RST_ERROR_WINDOW;
    model_p_gain               = RST_P_GAIN;
    model_i_gain               = RST_I_GAIN;
    model_limit                = RST_DRIVE_LIMIT;
    model_sum                  = '0;
    settings_used              = 1;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (k = 0; k < PROBE_N; k++) begin
      send_pos(probes[k].act, probes[k].target, probes[k].typed, probes[k].drive,
               probes[k].right);
    end
    settle();

    // reset settings, with a full drain halfway
    run_random(100, 60, 10, 40);
    settle();
    run_random(100, 60, 10, 40);
    settle();

    // wide window, integral only: full-scale errors drive the sum into saturation
    apply_settings(65535, 0, 1, 65535);
    run_random(320, 0, 100, 0);
    settle();

    // everything zero: only zero error keeps the sum, drive stuck at zero
    apply_settings(0, 0, 0, 0);
    run_random(100, 50, 10, 4);
    settle();

    // everything at full scale
    apply_settings(65535, 16777215, 1048575, 65535);
    run_random(150, 60, 15, 64);
    settle();

    // nonzero gains but a zero drive limit
    apply_settings(200, 840000, 2040, 0);
    run_random(100, 70, 5, 300);
    settle();

    for (k = 0; k < 3; k++) begin
      window = $urandom_range(0, 2000);
      apply_settings(window, $urandom_range(0, 2000000), $urandom_range(0, 100000),
                     $urandom_range(0, 65535));
      run_random(150, 70, 5, window + 50);
      settle();
    end

    repeat (8) @(negedge clk);
    mismatches += pending_drives.size();

    $display("run covered %0d position words under %0d register settings, %0d drive words compared",
             words_sent, settings_used, words_checked);
    $display("integral saturated on %0d ticks, drive clamped on %0d ticks", sat_ticks,
             clamp_ticks);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
